// ===== hw/rtl/hsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// hsrm_pkg
// Shared constants, types and helpers of the host suffix rule matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package hsrm_pkg;

	localparam int RULE_SLOTS  = 1024;
	localparam int POOL_BYTES  = 16384;
	localparam int HOST_BYTES  = 256;
	localparam int TABLE_SLOTS = 2048;

	localparam int RULE_AW  = $clog2(RULE_SLOTS);
	localparam int POOL_AW  = $clog2(POOL_BYTES);
	localparam int HOST_AW  = $clog2(HOST_BYTES);
	localparam int TABLE_AW = $clog2(TABLE_SLOTS);

	// counters that must also hold the full count
	localparam int RCNT_W = RULE_AW + 1;
	localparam int PCNT_W = POOL_AW + 1;
	localparam int HCNT_W = HOST_AW + 1;
	localparam int TCNT_W = TABLE_AW + 1;

	// table entry holds rule index + 1, zero is empty
	localparam int ENTRY_W = RCNT_W;
	// rule record: offset, length, type mask, allow, party
	localparam int META_W  = POOL_AW + HCNT_W + 8 + 1 + 2;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [7:0]  DOT_CHAR  = 8'h2e;

	// request kinds
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_RULE  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	// response kinds
	localparam logic [1:0] RESP_CLEARED = 2'd0;
	localparam logic [1:0] RESP_STORED  = 2'd1;
	localparam logic [1:0] RESP_DROPPED = 2'd2;
	localparam logic [1:0] RESP_ANSWER  = 2'd3;

	// byte walk modes
	localparam logic [1:0] WALK_COPY = 2'd0;
	localparam logic [1:0] WALK_SCAN = 2'd1;
	localparam logic [1:0] WALK_CMP  = 2'd2;

	typedef struct packed {
		logic [POOL_AW-1:0] off;
		logic [HCNT_W-1:0]  len;
		logic [7:0]         types;
		logic               allow;
		logic [1:0]         party;
	} meta_t;

	typedef struct packed {
		logic       clr_init;
		logic       clr_step;
		logic       take_byte;
		logic       meta_wr;
		logic       set_trunc;
		logic       walk_init;
		logic [1:0] walk_mode;
		logic       walk_step;
		logic       probe_init;
		logic       slot_adv;
		logic       rule_commit;
		logic       scan_init;
		logic       meta_latch;
		logic       hit_set;
		logic       next_suffix;
		logic       set_kind;
		logic [1:0] kind;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic room;
		logic walk_done;
		logic match;
		logic n_full;
		logic entry_zero;
		logic idx_ok;
		logic meta_ok;
		logic dot_found;
	} status_t;

	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		fnv_step = (h ^ {24'd0, b}) * FNV_PRIME;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hsrm_if.sv =====
// ----------------------------------------------------------------------------
// hsrm_if
// Request and response channels of the host suffix rule matcher.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsrm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] host_byte;
	logic       last_byte;
	logic       rule_allow;
	logic [7:0] rule_type_mask;
	logic [1:0] rule_party;
	logic [2:0] request_type;
	logic       cross_site;

	modport source (output valid, req_type, host_byte, last_byte, rule_allow,
		rule_type_mask, rule_party, request_type, cross_site, input ready);
	modport sink (input valid, req_type, host_byte, last_byte, rule_allow,
		rule_type_mask, rule_party, request_type, cross_site, output ready);
endinterface

interface hsrm_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] resp_kind;
	logic       allowed_hit;
	logic       blocked_hit;
	logic       block;
	logic       truncated;
	logic       over_length;

	modport source (output valid, resp_kind, allowed_hit, blocked_hit, block,
		truncated, over_length, input ready);
	modport sink (input valid, resp_kind, allowed_hit, blocked_hit, block,
		truncated, over_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hsrm_ram.sv =====
// ----------------------------------------------------------------------------
// hsrm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hsrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hsrm_datapath.sv =====
// ----------------------------------------------------------------------------
// hsrm_datapath
// Host buffer, rule store, string pool, slot table and their counters.
// ----------------------------------------------------------------------------
`default_nettype none

module hsrm_datapath import hsrm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cmd_t    cmd,
	output status_t      status,
	hsrm_in_if.sink      items,
	hsrm_out_if.source   results
);

	logic [HCNT_W-1:0]  fill_q;
	logic               cut_q;
	logic [31:0]        hash_q;
	logic [RCNT_W-1:0]  rule_total_q;
	logic [PCNT_W-1:0]  pool_used_q;
	logic               trunc_q;
	logic [TABLE_AW-1:0] clr_addr_q;

	logic               rallow_q;
	logic [7:0]         rtypes_q;
	logic [1:0]         rparty_q;
	logic [2:0]         qtype_q;
	logic               qthird_q;

	logic [HCNT_W-1:0]  k_q;
	logic [HCNT_W-1:0]  kp_q;
	logic               v_q;
	logic [1:0]         mode_q;
	logic               mismatch_q;

	logic [HCNT_W-1:0]  start_q;
	logic [HCNT_W-1:0]  dot_q;
	logic               dot_found_q;
	logic [31:0]        qhash_q;
	logic [TABLE_AW-1:0] slot_q;
	logic [TCNT_W-1:0]  n_q;
	meta_t              meta_q;
	logic               allow_hit_q;
	logic               block_hit_q;
	logic [1:0]         kind_q;

	logic [7:0]         buf_rdata;
	logic [7:0]         pool_rdata;
	logic [ENTRY_W-1:0] tbl_rdata;
	logic [META_W-1:0]  meta_rdata;
	meta_t              meta_rd;
	logic [ENTRY_W-1:0] idx;
	logic [HCNT_W-1:0]  limit;
	logic [HCNT_W-1:0]  qlen;
	logic [HCNT_W-1:0]  buf_ra;
	logic [PCNT_W:0]    room_pool;
	logic               byte_ok;
	meta_t              meta_new;

	logic               tbl_we;
	logic [TABLE_AW-1:0] tbl_wa;
	logic [ENTRY_W-1:0] tbl_wd;

	assign meta_rd   = meta_t'(meta_rdata);
	assign idx       = tbl_rdata - ENTRY_W'(1);
	assign limit     = (mode_q == WALK_CMP) ? meta_q.len : fill_q;
	assign qlen      = fill_q - start_q;
	assign buf_ra    = (mode_q == WALK_CMP) ? (start_q + k_q) : k_q;
	assign room_pool = (PCNT_W+1)'(POOL_BYTES) - {1'b0, pool_used_q};
	assign byte_ok   = (fill_q < HCNT_W'(HOST_BYTES));

	assign meta_new.off   = pool_used_q[POOL_AW-1:0];
	assign meta_new.len   = fill_q;
	assign meta_new.types = rtypes_q;
	assign meta_new.allow = rallow_q;
	assign meta_new.party = rparty_q;

	assign tbl_we = cmd.clr_step | cmd.rule_commit;
	assign tbl_wa = cmd.clr_step ? clr_addr_q : slot_q;
	assign tbl_wd = cmd.clr_step ? '0 : (rule_total_q + ENTRY_W'(1));

	always_comb begin
		status.clr_last   = (clr_addr_q == TABLE_AW'(TABLE_SLOTS - 1));
		status.room       = (rule_total_q < RCNT_W'(RULE_SLOTS)) &&
			(32'(rule_total_q) < 32'(TABLE_SLOTS)) &&
			((PCNT_W+1)'(fill_q) <= room_pool);
		status.walk_done  = (k_q == limit) && !v_q;
		status.match      = !mismatch_q;
		status.n_full     = (n_q == TCNT_W'(TABLE_SLOTS));
		status.entry_zero = (tbl_rdata == '0);
		status.idx_ok     = (idx < rule_total_q);
		status.meta_ok    = (meta_rd.len == qlen) && meta_rd.types[qtype_q] &&
			(!meta_rd.party[0] || qthird_q) && (!meta_rd.party[1] || !qthird_q);
		status.dot_found  = dot_found_q;
	end

	hsrm_ram #(.WIDTH(8), .DEPTH(HOST_BYTES)) u_host_buf (
		.clk   (clk),
		.we    (cmd.take_byte && byte_ok),
		.waddr (fill_q[HOST_AW-1:0]),
		.wdata (items.host_byte),
		.raddr (buf_ra[HOST_AW-1:0]),
		.rdata (buf_rdata)
	);

	hsrm_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_pool (
		.clk   (clk),
		.we    (v_q && (mode_q == WALK_COPY)),
		.waddr (POOL_AW'(pool_used_q + PCNT_W'(kp_q))),
		.wdata (buf_rdata),
		.raddr (POOL_AW'(meta_q.off + POOL_AW'(k_q))),
		.rdata (pool_rdata)
	);

	hsrm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_wa),
		.wdata (tbl_wd),
		.raddr (slot_q),
		.rdata (tbl_rdata)
	);

	hsrm_ram #(.WIDTH(META_W), .DEPTH(RULE_SLOTS)) u_meta (
		.clk   (clk),
		.we    (cmd.meta_wr),
		.waddr (rule_total_q[RULE_AW-1:0]),
		.wdata (META_W'(meta_new)),
		.raddr (idx[RULE_AW-1:0]),
		.rdata (meta_rdata)
	);

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			cut_q        <= 1'b0;
			hash_q       <= FNV_BASIS;
			rule_total_q <= '0;
			pool_used_q  <= '0;
			trunc_q      <= 1'b0;
			clr_addr_q   <= '0;
		end else begin
			if (cmd.clr_init) begin
				fill_q       <= '0;
				cut_q        <= 1'b0;
				hash_q       <= FNV_BASIS;
				rule_total_q <= '0;
				pool_used_q  <= '0;
				trunc_q      <= 1'b0;
				clr_addr_q   <= '0;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + TABLE_AW'(1);
			end
			if (cmd.take_byte) begin
				if (byte_ok) begin
					fill_q <= fill_q + HCNT_W'(1);
					hash_q <= fnv_step(hash_q, items.host_byte);
				end else begin
					cut_q <= 1'b1;
				end
			end
			if (cmd.set_trunc) begin
				trunc_q <= 1'b1;
			end
			if (cmd.rule_commit) begin
				rule_total_q <= rule_total_q + RCNT_W'(1);
				pool_used_q  <= pool_used_q + PCNT_W'(fill_q);
			end
			if (cmd.out_load) begin
				fill_q <= '0;
				cut_q  <= 1'b0;
				hash_q <= FNV_BASIS;
			end
		end
	end

	// walk pipeline valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (cmd.walk_init) begin
			v_q <= 1'b0;
		end else if (cmd.walk_step) begin
			v_q <= (k_q != limit);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.take_byte && items.last_byte) begin
			rallow_q    <= items.rule_allow;
			rtypes_q    <= items.rule_type_mask;
			rparty_q    <= items.rule_party;
			qtype_q     <= items.request_type;
			qthird_q    <= items.cross_site;
			start_q     <= '0;
			allow_hit_q <= 1'b0;
			block_hit_q <= 1'b0;
		end
		if (cmd.set_kind) begin
			kind_q <= cmd.kind;
		end
		if (cmd.clr_init) begin
			kind_q <= RESP_CLEARED;
		end
		if (cmd.walk_init) begin
			mode_q     <= cmd.walk_mode;
			k_q        <= (cmd.walk_mode == WALK_SCAN) ? start_q : '0;
			mismatch_q <= 1'b0;
		end
		if (cmd.walk_step) begin
			if (k_q != limit) begin
				k_q  <= k_q + HCNT_W'(1);
				kp_q <= k_q;
			end
			if (v_q && mode_q == WALK_SCAN) begin
				qhash_q <= fnv_step(qhash_q, buf_rdata);
				if (buf_rdata == DOT_CHAR && !dot_found_q) begin
					dot_found_q <= 1'b1;
					dot_q       <= kp_q;
				end
			end
			if (v_q && mode_q == WALK_CMP && buf_rdata != pool_rdata) begin
				mismatch_q <= 1'b1;
			end
		end
		if (cmd.scan_init) begin
			qhash_q     <= FNV_BASIS;
			dot_found_q <= 1'b0;
		end
		if (cmd.probe_init) begin
			slot_q <= (mode_q == WALK_COPY) ? hash_q[TABLE_AW-1:0] : qhash_q[TABLE_AW-1:0];
			n_q    <= '0;
		end
		if (cmd.slot_adv) begin
			slot_q <= slot_q + TABLE_AW'(1);
			n_q    <= n_q + TCNT_W'(1);
		end
		if (cmd.meta_latch) begin
			meta_q <= meta_rd;
		end
		if (cmd.hit_set) begin
			if (meta_q.allow) begin
				allow_hit_q <= 1'b1;
			end else begin
				block_hit_q <= 1'b1;
			end
		end
		if (cmd.next_suffix) begin
			start_q <= dot_q + HCNT_W'(1);
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			results.resp_kind   <= kind_q;
			results.allowed_hit <= (kind_q == RESP_ANSWER) && allow_hit_q;
			results.blocked_hit <= (kind_q == RESP_ANSWER) && block_hit_q;
			results.block       <= (kind_q == RESP_ANSWER) && block_hit_q && !allow_hit_q;
			results.truncated   <= (kind_q != RESP_CLEARED) && trunc_q;
			results.over_length <= (kind_q != RESP_CLEARED) && cut_q;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hsrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// hsrm_ctrl
// Sequencer for clear sweep, rule insert and query suffix probing.
// ----------------------------------------------------------------------------
`default_nettype none

module hsrm_ctrl import hsrm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_kind,
	input  wire logic       in_last,
	input  wire logic       out_ready,
	input  wire status_t    status,
	output cmd_t            cmd,
	output logic            in_ready,
	output logic            out_valid
);

	localparam logic [3:0] ST_CLR     = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_RCHK    = 4'd2;
	localparam logic [3:0] ST_COPY    = 4'd3;
	localparam logic [3:0] ST_RP_RD   = 4'd4;
	localparam logic [3:0] ST_RP_CHK  = 4'd5;
	localparam logic [3:0] ST_QS_INIT = 4'd6;
	localparam logic [3:0] ST_QSCAN   = 4'd7;
	localparam logic [3:0] ST_QP_RD   = 4'd8;
	localparam logic [3:0] ST_QP_CHK  = 4'd9;
	localparam logic [3:0] ST_QM_CHK  = 4'd10;
	localparam logic [3:0] ST_QCMP    = 4'd11;
	localparam logic [3:0] ST_QNEXT   = 4'd12;
	localparam logic [3:0] ST_DONE    = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       clr_resp_q;
	logic       out_valid_q;
	logic       out_free;
	logic       acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign acc       = in_ready && in_valid;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = clr_resp_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					if (in_kind == REQ_CLEAR) begin
						cmd.clr_init = 1'b1;
						state_d      = ST_CLR;
					end else if (in_kind == REQ_RULE || in_kind == REQ_QUERY) begin
						cmd.take_byte = 1'b1;
						if (in_last) begin
							state_d = (in_kind == REQ_RULE) ? ST_RCHK : ST_QS_INIT;
						end
					end
				end
			end
			ST_RCHK: begin
				if (status.room) begin
					cmd.meta_wr   = 1'b1;
					cmd.walk_init = 1'b1;
					cmd.walk_mode = WALK_COPY;
					state_d       = ST_COPY;
				end else begin
					cmd.set_trunc = 1'b1;
					cmd.set_kind  = 1'b1;
					cmd.kind      = RESP_DROPPED;
					state_d       = ST_DONE;
				end
			end
			ST_COPY: begin
				cmd.walk_step = 1'b1;
				if (status.walk_done) begin
					cmd.probe_init = 1'b1;
					state_d        = ST_RP_RD;
				end
			end
			ST_RP_RD: begin
				state_d = ST_RP_CHK;
			end
			ST_RP_CHK: begin
				if (status.entry_zero) begin
					cmd.rule_commit = 1'b1;
					cmd.set_kind    = 1'b1;
					cmd.kind        = RESP_STORED;
					state_d         = ST_DONE;
				end else begin
					cmd.slot_adv = 1'b1;
					state_d      = ST_RP_RD;
				end
			end
			ST_QS_INIT: begin
				cmd.scan_init = 1'b1;
				cmd.walk_init = 1'b1;
				cmd.walk_mode = WALK_SCAN;
				state_d       = ST_QSCAN;
			end
			ST_QSCAN: begin
				cmd.walk_step = 1'b1;
				if (status.walk_done) begin
					cmd.probe_init = 1'b1;
					state_d        = ST_QP_RD;
				end
			end
			ST_QP_RD: begin
				state_d = status.n_full ? ST_QNEXT : ST_QP_CHK;
			end
			ST_QP_CHK: begin
				if (status.entry_zero) begin
					state_d = ST_QNEXT;
				end else if (status.idx_ok) begin
					state_d = ST_QM_CHK;
				end else begin
					cmd.slot_adv = 1'b1;
					state_d      = ST_QP_RD;
				end
			end
			ST_QM_CHK: begin
				cmd.meta_latch = 1'b1;
				if (status.meta_ok) begin
					cmd.walk_init = 1'b1;
					cmd.walk_mode = WALK_CMP;
					state_d       = ST_QCMP;
				end else begin
					cmd.slot_adv = 1'b1;
					state_d      = ST_QP_RD;
				end
			end
			ST_QCMP: begin
				cmd.walk_step = 1'b1;
				if (status.walk_done) begin
					cmd.hit_set  = status.match;
					cmd.slot_adv = 1'b1;
					state_d      = ST_QP_RD;
				end
			end
			ST_QNEXT: begin
				if (status.dot_found) begin
					cmd.next_suffix = 1'b1;
					state_d         = ST_QS_INIT;
				end else begin
					cmd.set_kind = 1'b1;
					cmd.kind     = RESP_ANSWER;
					state_d      = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_resp_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.clr_init) begin
				clr_resp_q <= 1'b1;
			end else if (cmd.out_load) begin
				clr_resp_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/host_suffix_rule_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// host_suffix_rule_matcher_unit
// Domain rule store with FNV-1a hashed, linearly probed suffix lookup.
// ----------------------------------------------------------------------------
// Non-final host bytes and reserved requests: one request per cycle, no response.
// Rule end: the time to the response is set by the byte copy into the string
//   pool and the slot table probe chain.
// Query end: each dot-suffix is hashed and stepped, then its slot table probe
//   chain is read slot by slot and each candidate rule is compared byte by byte;
//   after the last suffix the response is loaded.
// Clear: one table slot per cycle, and the response after the sweep.
// After reset the same sweep runs with no response and no request taken;
//   counters and flags are zeroed at once.
`default_nettype none

module host_suffix_rule_matcher_unit import hsrm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hsrm_in_if.sink    items,
	hsrm_out_if.source results
);

	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	// requests are taken only while the sequencer is idle
	assign items.ready = in_ready;

	// sequencer: owns state, handshake and the response valid bit
	hsrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_kind   (items.req_type),
		.in_last   (items.last_byte),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (results.valid)
	);

	// storage, counters and the response register
	hsrm_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.items   (items),
		.results (results)
	);

endmodule

`default_nettype wire

// ===== tb/hsrm_checker.sv =====
// ----------------------------------------------------------------------------
// hsrm_checker
// Watches both channels, predicts each response and compares it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module hsrm_checker import hsrm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	hsrm_in_if        items,
	hsrm_out_if       results,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0] kind;
		logic       allowed;
		logic       blocked;
		logic       block;
		logic       trunc;
		logic       over;
	} answer_t;

	answer_t    answer_q[$];

	// shadow state of the rule store
	logic [7:0]         pool_mem [POOL_BYTES];
	int                 r_off [RULE_SLOTS];
	int                 r_len [RULE_SLOTS];
	logic [7:0]         r_types [RULE_SLOTS];
	logic               r_allow [RULE_SLOTS];
	logic [1:0]         r_party [RULE_SLOTS];
	logic [ENTRY_W-1:0] slot_mem [TABLE_SLOTS];
	int                 rule_cnt;
	int                 pool_cnt;
	logic               trunc_st;
	logic [7:0]         hbuf [HOST_BYTES];
	int                 hfill;
	logic [31:0]        hrun;
	logic               hcut;

	initial begin
		fail_count = 0;
		foreach (slot_mem[i]) slot_mem[i] = '0;
		rule_cnt = 0;
		pool_cnt = 0;
		trunc_st = 1'b0;
		hfill = 0;
		hrun = FNV_BASIS;
		hcut = 1'b0;
	end

	assign pending = answer_q.size();

	function automatic int slot_of(input logic [31:0] h);
		return int'(h & (TABLE_SLOTS - 1));
	endfunction

	function automatic logic [1:0] commit_rule(input logic al, input logic [7:0] ty,
		input logic [1:0] pa);
		int slot;
		int n;
		if (rule_cnt >= RULE_SLOTS || rule_cnt >= TABLE_SLOTS || hfill > POOL_BYTES - pool_cnt) begin
			trunc_st = 1'b1;
			return RESP_DROPPED;
		end
		r_off[rule_cnt] = pool_cnt;
		r_len[rule_cnt] = hfill;
		r_types[rule_cnt] = ty;
		r_allow[rule_cnt] = al;
		r_party[rule_cnt] = pa;
		for (int i = 0; i < hfill; i++) pool_mem[pool_cnt + i] = hbuf[i];
		pool_cnt += hfill;
		slot = slot_of(hrun);
		for (n = 0; n < TABLE_SLOTS && slot_mem[slot] != 0; n++) slot = (slot + 1) % TABLE_SLOTS;
		slot_mem[slot] = ENTRY_W'(rule_cnt + 1);
		rule_cnt++;
		return RESP_STORED;
	endfunction

	// walk every dot-suffix and its probe chain
	task automatic lookup_suffixes(input logic [2:0] rtype, input logic third,
		output logic al_hit, output logic bl_hit);
		int start;
		int len;
		int slot;
		int idx;
		int d;
		logic [31:0] h;
		logic same;
		al_hit = 1'b0;
		bl_hit = 1'b0;
		start = 0;
		forever begin
			len = hfill - start;
			h = FNV_BASIS;
			for (int i = start; i < hfill; i++) h = (h ^ {24'd0, hbuf[i]}) * FNV_PRIME;
			slot = slot_of(h);
			for (int n = 0; n < TABLE_SLOTS && slot_mem[slot] != 0; n++) begin
				idx = int'(slot_mem[slot]) - 1;
				if (idx < rule_cnt && r_len[idx] == len) begin
					same = 1'b1;
					for (int i = 0; i < len; i++)
						if (pool_mem[r_off[idx] + i] != hbuf[start + i]) same = 1'b0;
					if (same && r_types[idx][rtype] && (!r_party[idx][0] || third)
						&& (!r_party[idx][1] || !third)) begin
						if (r_allow[idx]) al_hit = 1'b1;
						else bl_hit = 1'b1;
					end
				end
				slot = (slot + 1) % TABLE_SLOTS;
			end
			for (d = start; d < hfill && hbuf[d] != DOT_CHAR; d++);
			if (d >= hfill) break;
			start = d + 1;
		end
	endtask

	task automatic predict_request();
		answer_t a;
		logic al_hit;
		logic bl_hit;
		a = '{default: 1'b0};
		if (items.req_type == REQ_CLEAR) begin
			foreach (slot_mem[i]) slot_mem[i] = '0;
			rule_cnt = 0;
			pool_cnt = 0;
			trunc_st = 1'b0;
			hfill = 0;
			hrun = FNV_BASIS;
			hcut = 1'b0;
			a.kind = RESP_CLEARED;
			answer_q.push_back(a);
		end else if (items.req_type == REQ_RULE || items.req_type == REQ_QUERY) begin
			if (hfill < HOST_BYTES) begin
				hbuf[hfill] = items.host_byte;
				hfill++;
				hrun = (hrun ^ {24'd0, items.host_byte}) * FNV_PRIME;
			end else begin
				hcut = 1'b1;
			end
			if (items.last_byte) begin
				a.over = hcut;
				if (items.req_type == REQ_RULE) begin
					a.kind = commit_rule(items.rule_allow, items.rule_type_mask, items.rule_party);
				end else begin
					lookup_suffixes(items.request_type, items.cross_site, al_hit, bl_hit);
					a.kind = RESP_ANSWER;
					a.allowed = al_hit;
					a.blocked = bl_hit;
					a.block = bl_hit && !al_hit;
				end
				a.trunc = trunc_st;
				hfill = 0;
				hrun = FNV_BASIS;
				hcut = 1'b0;
				answer_q.push_back(a);
			end
		end
	endtask

	always @(posedge clk) begin
		answer_t e;
		if (arst_n) begin
			// responses first: a response never belongs to a request taken at this edge
			if (results.valid && results.ready) begin
				if (answer_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected response kind=%0d", results.resp_kind);
				end else begin
					e = answer_q.pop_front();
					if (e.kind !== results.resp_kind || e.allowed !== results.allowed_hit
						|| e.blocked !== results.blocked_hit || e.block !== results.block
						|| e.trunc !== results.truncated || e.over !== results.over_length) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch exp kind=%0d a=%b b=%b blk=%b tr=%b ov=%b | got kind=%0d a=%b b=%b blk=%b tr=%b ov=%b",
								e.kind, e.allowed, e.blocked, e.block, e.trunc, e.over,
								results.resp_kind, results.allowed_hit, results.blocked_hit,
								results.block, results.truncated, results.over_length);
					end
				end
			end
			if (items.valid && items.ready) predict_request();
		end
	end

endmodule

`default_nettype wire

// ===== tb/host_suffix_rule_matcher_unit_tb.sv =====
// ----------------------------------------------------------------------------
// host_suffix_rule_matcher_unit_tb
// Streams rule, query and clear requests into the matcher with random idling
// and a long response stall; a checker alongside predicts every response.
// ----------------------------------------------------------------------------
`default_nettype none

module host_suffix_rule_matcher_unit_tb import hsrm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] byte_q_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	int   sent = 0;
	logic calm = 1'b0;      // no idling on either side while set
	int   stall_token = 0;  // bumped by stimulus to request a long response stall
	int   stall_seen = 0;
	int   stall_left = 0;

	hsrm_in_if  items();
	hsrm_out_if results();

	host_suffix_rule_matcher_unit u_top (
		.clk(clk), .arst_n(arst_n), .items(items.sink), .results(results.source)
	);

	hsrm_checker u_chk (
		.clk(clk), .arst_n(arst_n), .items(items), .results(results),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	// watchdog: covers the reset sweep, every clear sweep and the long stall
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 4000000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// response side: random back-pressure plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else if (stall_token != stall_seen) begin
			stall_seen <= stall_token;
			stall_left <= 3000;
			results.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			results.ready <= 1'b0;
		end else begin
			results.ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
		end
	end

	initial begin
		items.valid = 1'b0;
		items.req_type = REQ_CLEAR;
		items.host_byte = '0;
		items.last_byte = 1'b0;
		items.rule_allow = 1'b0;
		items.rule_type_mask = '0;
		items.rule_party = '0;
		items.request_type = '0;
		items.cross_site = 1'b0;
	end

	// one request; valid stays high across back-to-back requests
	task automatic push_request(input logic [1:0] kind, input logic [7:0] hb, input logic lb,
		input logic al, input logic [7:0] mask, input logic [1:0] party,
		input logic [2:0] rtype, input logic third);
		if (!calm)
			while ($urandom_range(99) < 11) begin
				items.valid <= 1'b0;
				@(posedge clk);
			end
		items.valid <= 1'b1;
		items.req_type <= kind;
		items.host_byte <= hb;
		items.last_byte <= lb;
		// fields that only count on the last byte carry noise elsewhere
		items.rule_allow <= lb ? al : 1'($urandom);
		items.rule_type_mask <= lb ? mask : 8'($urandom);
		items.rule_party <= lb ? party : 2'($urandom);
		items.request_type <= lb ? rtype : 3'($urandom);
		items.cross_site <= lb ? third : 1'($urandom);
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		sent++;
	endtask

	task automatic push_host(input logic [1:0] kind, input byte_q_t h, input logic al,
		input logic [7:0] mask, input logic [1:0] party, input logic [2:0] rtype,
		input logic third);
		foreach (h[i])
			push_request(kind, h[i], i == h.size() - 1, al, mask, party, rtype, third);
	endtask

	task automatic push_clear();
		push_request(REQ_CLEAR, 8'($urandom), 1'($urandom), 1'b0, 8'hff, 2'd0, 3'd0, 1'b0);
	endtask

	// small label set so rules and queries collide on suffixes often
	function automatic byte_q_t label_bytes(input int k);
		case (k)
			0: return '{8'h61, 8'h64};
			1: return '{8'h78};
			2: return '{8'h63, 8'h64, 8'h6e};
			default: return '{8'h6d};
		endcase
	endfunction

	function automatic byte_q_t pick_host(input int labels);
		byte_q_t h;
		for (int i = 0; i < labels; i++) begin
			if (i > 0) h.push_back(DOT_CHAR);
			h = {h, label_bytes($urandom_range(3))};
		end
		return h;
	endfunction

	function automatic byte_q_t noise_host(input int n);
		byte_q_t h;
		for (int i = 0; i < n; i++) h.push_back(8'($urandom));
		return h;
	endfunction

	function automatic logic [7:0] rand_mask();
		return ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
	endfunction

	function automatic logic [1:0] rand_party();
		return ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
	endfunction

	initial begin
		byte_q_t h;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		push_clear();
		push_host(REQ_QUERY, '{8'h61}, 0, 0, 0, 3'd0, 0);                 // empty table
		push_host(REQ_RULE, pick_host(0) , 0, 0, 0, 0, 0);                // nothing (empty queue)
		h = '{8'h61, 8'h64, DOT_CHAR, 8'h78};                              // "ad.x"
		push_host(REQ_RULE, h, 1'b0, 8'hff, 2'd0, 3'd0, 1'b0);            // block any
		push_host(REQ_QUERY, {label_bytes(2), DOT_CHAR, h}, 0, 0, 0, 3'd7, 1'b0); // suffix hit
		push_host(REQ_RULE, h, 1'b1, 8'h08, 2'd1, 3'd0, 1'b0);            // allow, third only
		push_host(REQ_QUERY, h, 0, 0, 0, 3'd3, 1'b1);                      // allowed wins
		push_host(REQ_QUERY, h, 0, 0, 0, 3'd3, 1'b0);                      // first party
		push_host(REQ_RULE, h, 1'b1, 8'h01, 2'd2, 3'd0, 1'b0);            // first-party only
		push_host(REQ_RULE, label_bytes(1), 1'b0, 8'h00, 2'd0, 3'd0, 1'b0); // zero mask
		push_host(REQ_RULE, label_bytes(3), 1'b0, 8'hff, 2'd3, 3'd0, 1'b0); // both party bits
		push_host(REQ_QUERY, {label_bytes(3), DOT_CHAR, label_bytes(1)}, 0, 0, 0, 3'd0, 1'b1);
		push_host(REQ_QUERY, {h, DOT_CHAR}, 0, 0, 0, 3'd0, 1'b0);         // trailing dot
		push_request(2'd3, 8'hff, 1'b1, 1'b1, 8'hff, 2'd3, 3'd7, 1'b1);   // reserved kind
		push_host(REQ_RULE, '{8'h00, 8'hff}, 1'b1, 8'h80, 2'd0, 3'd0, 1'b0);
		push_host(REQ_QUERY, '{8'h00, 8'hff}, 0, 0, 0, 3'd7, 1'b1);
		// mixed stream: rule bytes finished by a query byte
		push_request(REQ_RULE, 8'h61, 1'b0, 0, 0, 0, 0, 0);
		push_request(REQ_RULE, 8'h64, 1'b0, 0, 0, 0, 0, 0);
		push_request(REQ_QUERY, DOT_CHAR, 1'b0, 0, 0, 0, 0, 0);
		push_request(REQ_QUERY, 8'h78, 1'b1, 0, 0, 0, 3'd2, 1'b0);
		push_host(REQ_RULE, noise_host(258), 1'b0, 8'hff, 2'd0, 3'd0, 1'b0); // over length
		push_host(REQ_QUERY, noise_host(257), 0, 0, 0, 3'd1, 1'b1);
		push_clear();

		// --- random: first a calm stretch, then a long response hold-off ---
		for (int it = 0; sent < 850; it++) begin
			if (it == 0) calm <= 1'b1;
			if (it == 12) calm <= 1'b0;
			if (it == 20) stall_token <= stall_token + 1;
			pick = $urandom_range(99);
			if (pick < 40)
				push_host(REQ_RULE, pick_host($urandom_range(3, 1)), 1'($urandom),
					rand_mask(), rand_party(), 3'($urandom), 1'($urandom));
			else if (pick < 85)
				push_host(REQ_QUERY, pick_host($urandom_range(4, 1)), 1'($urandom),
					8'($urandom), 2'($urandom), 3'($urandom), 1'($urandom));
			else if (pick < 88)
				push_clear();
			else if (pick < 91)
				push_request(2'd3, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
					2'($urandom), 3'($urandom), 1'($urandom));
			else if (pick < 95)
				push_host(pick[0] ? REQ_RULE : REQ_QUERY, noise_host($urandom_range(6, 1)),
					1'($urandom), rand_mask(), rand_party(), 3'($urandom), 1'($urandom));
			else if (pick < 99)
				push_host(REQ_QUERY, {pick_host(2), DOT_CHAR}, 0, 0, 0, 3'($urandom), 1'($urandom));
			else
				push_host(pick[0] ? REQ_RULE : REQ_QUERY, noise_host($urandom_range(280, 250)),
					1'($urandom), rand_mask(), rand_party(), 3'($urandom), 1'($urandom));
		end
		items.valid <= 1'b0;

		// drain, then watch for stray responses
		while (pending != 0) @(posedge clk);
		repeat (3000) @(posedge clk);

		$display("Covered directed match cases, reserved and mixed requests, over-length hosts");
		$display("and %0d requests in all under idling, a calm stretch and a long response stall.",
			sent);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/hsrm_pkg.sv
hw/rtl/hsrm_if.sv
hw/rtl/hsrm_ram.sv
hw/rtl/hsrm_datapath.sv
hw/rtl/hsrm_ctrl.sv
hw/rtl/host_suffix_rule_matcher_unit.sv
tb/hsrm_checker.sv
tb/host_suffix_rule_matcher_unit_tb.sv
